@@ rtl/four_level_symbol_framer_assert.svh @@
// Assertion macros used by the framer top level.
`ifndef FOUR_LEVEL_SYMBOL_FRAMER_ASSERT_SVH
`define FOUR_LEVEL_SYMBOL_FRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/fsfr_pkg.sv @@
`timescale 1ns / 1ps

package fsfr_pkg;

   // Sizes and defaults.
   localparam int unsigned FSFR_MAX_BYTES = 32;
   localparam int unsigned FSFR_CMD_DEPTH = 2;
   localparam int unsigned COUNT_W        = 6;
   localparam int unsigned CSR_ADDR_W     = 3;
   localparam int unsigned LEVEL_W        = 8;
   localparam int unsigned NUM_LEVELS     = 4;
   localparam int unsigned HDR_LEN        = 10;
   localparam int unsigned FTR_LEN        = 5;
   localparam int unsigned POS_W          = 4;

   // Positions in the symbol sequence of one command.
   localparam logic [POS_W-1:0] POS_BODY   = 4'd10;
   localparam logic [POS_W-1:0] POS_PARITY = 4'd14;
   localparam logic [POS_W-1:0] POS_IDLE   = 4'd15;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_SYM0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_SYM1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_SYM2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEVEL_SYM3 = 3'd3;

   typedef logic [NUM_LEVELS-1:0][LEVEL_W-1:0] levels_type;

   // Drive levels after reset, index 0 in the lowest byte.
   localparam levels_type LEVELS_RESET = {8'd255, 8'd170, 8'd85, 8'd0};

   // Fixed header and footer, element 0 sent first.
   localparam logic [HDR_LEN-1:0][1:0] HDR_SYMS =
      {2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0};
   localparam logic [FTR_LEN-1:0][1:0] FTR_SYMS =
      {2'd2, 2'd0, 2'd0, 2'd0, 2'd0};

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_END  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         symbol;
      logic [LEVEL_W-1:0] drive_level;
      logic               last_of_run;
   } rsp_payload_type;

   // Classified work handed from the front end to the symbol sequencer.
   typedef struct packed {
      opcode_type  opcode;
      logic        with_header;
      logic [7:0]  data_byte;
   } cmd_type;

   typedef struct packed {
      logic               in_message;
      logic [COUNT_W-1:0] byte_count;
   } front_status_type;

   // Symbol sent at a given position of a command.
   function automatic logic [1:0] frame_symbol(cmd_type cmd, logic [POS_W-1:0] pos);
      logic [POS_W-1:0] off;
      logic [1:0]       sym;
      off = pos - POS_BODY;
      if (pos < POS_BODY) begin
         sym = HDR_SYMS[pos];
      end else if (cmd.opcode == OP_DATA) begin
         case (off)
            4'd0:    sym = cmd.data_byte[7:6];
            4'd1:    sym = cmd.data_byte[5:4];
            4'd2:    sym = cmd.data_byte[3:2];
            4'd3:    sym = cmd.data_byte[1:0];
            default: sym = {1'b0, ^cmd.data_byte};
         endcase
      end else if (off < POS_W'(FTR_LEN)) begin
         sym = FTR_SYMS[off[2:0]];
      end else begin
         sym = 2'd0;
      end
      return sym;
   endfunction

   // True at the final position of a command.
   function automatic logic frame_last(cmd_type cmd, logic [POS_W-1:0] pos);
      return (cmd.opcode == OP_DATA) ? (pos == POS_PARITY) : (pos == POS_IDLE);
   endfunction

endpackage

@@ rtl/fsfr_cmd_queue.sv @@
`timescale 1ns / 1ps

module fsfr_cmd_queue
   import fsfr_pkg::*;
#(
   parameter int unsigned DEPTH = FSFR_CMD_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W + 1)'(DEPTH);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/fsfr_front.sv @@
`timescale 1ns / 1ps

module fsfr_front
   import fsfr_pkg::*;
#(
   parameter int unsigned MAX_BYTES = FSFR_MAX_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  req_payload_type  req_payload,
   input  logic             q_full,
   output logic             q_push,
   output cmd_type          q_cmd,
   output front_status_type status
);

   logic               in_message_ff, in_message_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic               accept, dropped;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // A data byte past the message limit produces nothing.
   assign dropped = (req_payload.opcode == OP_DATA) &&
                    (byte_count_ff >= COUNT_W'(MAX_BYTES));

   assign q_push            = accept && !dropped;
   assign q_cmd.opcode      = req_payload.opcode;
   assign q_cmd.with_header = !in_message_ff;
   assign q_cmd.data_byte   = req_payload.data_byte;

   // Message state follows each accepted transaction.
   always_comb begin
      in_message_in = in_message_ff;
      byte_count_in = byte_count_ff;
      if (accept) begin
         if (req_payload.opcode == OP_END) begin
            in_message_in = 1'b0;
            byte_count_in = '0;
         end else if (!dropped) begin
            in_message_in = 1'b1;
            byte_count_in = byte_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
         byte_count_ff <= '0;
      end else begin
         in_message_ff <= in_message_in;
         byte_count_ff <= byte_count_in;
      end
   end

   assign status.in_message = in_message_ff;
   assign status.byte_count = byte_count_ff;

endmodule

@@ rtl/fsfr_back.sv @@
`timescale 1ns / 1ps

module fsfr_back
   import fsfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  cmd_type         q_head,
   output logic            q_pop,
   input  levels_type      levels,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_payload_type rsp_payload
);

   logic             active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic [POS_W-1:0] start_pos, cur_pos;
   logic [1:0]       sym;
   logic             last, advance;

   // Position of the symbol to send next for the command at the head.
   assign start_pos = q_head.with_header ? '0 : POS_BODY;
   assign cur_pos   = active_ff ? pos_ff : start_pos;
   assign sym       = frame_symbol(q_head, cur_pos);
   assign last      = frame_last(q_head, cur_pos);

   // One symbol moves into the output register whenever a command is queued and the register is free or drained.
   assign advance = !q_empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop   = advance && last;

   always_comb begin
      active_in      = active_ff;
      pos_in         = pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_pop;
      rsp_payload_in = rsp_payload_ff;
      if (advance) begin
         active_in                  = !last;
         pos_in                     = cur_pos + 1'b1;
         rsp_valid_in               = 1'b1;
         rsp_payload_in.symbol      = sym;
         rsp_payload_in.drive_level = levels[sym];
         rsp_payload_in.last_of_run = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_empty   = !rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ rtl/four_level_symbol_framer.sv @@
// Four-level symbol framer. Push message bytes (opcode data) and an end
// transaction (opcode end); pop symbols with their configured drive levels.
// The first transaction of a message is preceded by a ten-symbol header; each
// byte gives four symbols, most significant pair first, and an even-parity
// symbol; an end gives a five-symbol footer and one idle symbol. Bytes beyond
// MAX_BYTES in one message are dropped silently. The sequencer sends one
// symbol per cycle while the output register is free or drained; a byte gives
// 5 symbols (15 with the header) and an end 6 (16 with the header). A command
// queue of CMD_DEPTH entries lets bytes be taken while earlier ones are still
// being sent. Drive levels are written through the csr port at indexes 0 to 3
// and should only change while no transaction is in flight.
`timescale 1ns / 1ps

`include "four_level_symbol_framer_assert.svh"

module four_level_symbol_framer
   import fsfr_pkg::*;
#(
   parameter int unsigned MAX_BYTES = FSFR_MAX_BYTES,
   parameter int unsigned CMD_DEPTH = FSFR_CMD_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  req_payload_type       req_payload,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [LEVEL_W-1:0]    csr_wdata
);

   levels_type       levels_ff, levels_in;
   front_status_type status;
   logic             q_full, q_push, q_empty, q_pop;
   cmd_type          q_cmd, q_head;

   // Drive level registers; writes to unused indexes are ignored.
   always_comb begin
      levels_in = levels_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_LEVEL_SYM0: levels_in[0] = csr_wdata;
            CSR_LEVEL_SYM1: levels_in[1] = csr_wdata;
            CSR_LEVEL_SYM2: levels_in[2] = csr_wdata;
            CSR_LEVEL_SYM3: levels_in[3] = csr_wdata;
            default:        levels_in    = levels_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RESET;
      end else begin
         levels_ff <= levels_in;
      end
   end

   // Front end: message state and classification.
   fsfr_front #(
      .MAX_BYTES (MAX_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_cmd),
      .status      (status)
   );

   // Command queue between the two halves.
   fsfr_cmd_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   // Back end: symbol sequencer and output register.
   fsfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .levels      (levels_ff),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

   // The last symbol of a run is either parity or idle, never above one.
   `FSFR_ASSERT_SAME(a_last_symbol_low, clock, reset, !rsp_empty && rsp_payload.last_of_run, rsp_payload.symbol[1] == 1'b0, "last symbol of a run above one")

   // The byte count never passes the message limit.
   `FSFR_ASSERT_SAME(a_count_limit, clock, reset, 1'b1, status.byte_count <= COUNT_W'(MAX_BYTES), "byte count beyond limit")

   // Outside a message no bytes are counted.
   `FSFR_ASSERT_SAME(a_idle_count_zero, clock, reset, !status.in_message, status.byte_count == '0, "bytes counted outside a message")

   // An accepted end transaction closes the message.
   `FSFR_ASSERT_NEXT(a_end_closes, clock, reset, req_push && !req_full && req_payload.opcode == OP_END, !status.in_message, "message still open after end")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import fsfr_pkg::*;

   localparam int SETTLE_CYCLES  = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MAX_REPORTS    = 40;
   localparam int LEN_UNCHECKED  = -1;

   // Framing sequences, first symbol sent first.
   localparam logic [1:0] HEADER_SYMS [HDR_LEN] =
      '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3};
   localparam logic [1:0] FOOTER_SYMS [FTR_LEN] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2};
   localparam logic [1:0] IDLE_SYM = 2'd0;

   // One row of the directed sequence. A row repeated more than once sends
   // random bytes, and exp_len is the number of symbols one transaction gives.
   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  data_byte;
      int          reps;
      int          exp_len;
   } directed_row_type;

   localparam int NUM_ROWS = 16;
   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{OP_END,  8'h00,  1, 16},              // empty message
      '{OP_DATA, 8'h00,  1, 15},              // zero byte with header
      '{OP_DATA, 8'hFF,  1,  5},
      '{OP_DATA, 8'h01,  1,  5},              // odd parity
      '{OP_DATA, 8'h80,  1,  5},
      '{OP_DATA, 8'h1B,  1,  5},              // symbols 0, 1, 2, 3
      '{OP_DATA, 8'hE4,  1,  5},              // symbols 3, 2, 1, 0
      '{OP_END,  8'hFF,  1,  6},
      '{OP_END,  8'h5A,  1, 16},              // a second empty message
      '{OP_DATA, 8'hA5,  1, 15},
      '{OP_DATA, 8'h00, 31, LEN_UNCHECKED},   // fill the message to its limit
      '{OP_DATA, 8'h3C,  1,  0},              // dropped, message full
      '{OP_DATA, 8'hFF,  1,  0},              // dropped, message full
      '{OP_END,  8'h00,  1,  6},
      '{OP_DATA, 8'h55,  1, 15},              // header again after the overflow
      '{OP_END,  8'h00,  1,  6}
   };

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_push    = 1'b0;
   logic                  req_full;
   req_payload_type       req_payload = '0;
   logic                  rsp_empty;
   logic                  rsp_pop     = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_we      = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr    = '0;
   logic [LEVEL_W-1:0]    csr_wdata   = '0;

   // Predicted framer state and the symbols still owed by the block.
   logic [LEVEL_W-1:0] drive_levels [NUM_LEVELS] = '{8'd0, 8'd85, 8'd170, 8'd255};
   logic               header_sent      = 1'b0;
   int                 bytes_in_message = 0;
   rsp_payload_type    expected_symbols [$];

   int mismatches     = 0;
   int symbols_seen   = 0;
   int idle_cycles    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   four_level_symbol_framer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
   endtask

   // Works out the symbols that one accepted transaction gives and queues them.
   function automatic int predict_symbols(req_payload_type item);
      logic [1:0]      run_syms [$];
      rsp_payload_type sym_out;
      if (item.opcode == OP_DATA && bytes_in_message >= FSFR_MAX_BYTES) begin
         return 0;
      end
      if (!header_sent) begin
         foreach (HEADER_SYMS[i]) run_syms.push_back(HEADER_SYMS[i]);
         header_sent = 1'b1;
      end
      if (item.opcode == OP_DATA) begin
         for (int i = 3; i >= 0; i--) begin
            run_syms.push_back(item.data_byte[2*i +: 2]);
         end
         run_syms.push_back({1'b0, ^item.data_byte});
         bytes_in_message++;
      end else begin
         foreach (FOOTER_SYMS[i]) run_syms.push_back(FOOTER_SYMS[i]);
         run_syms.push_back(IDLE_SYM);
         header_sent      = 1'b0;
         bytes_in_message = 0;
      end
      foreach (run_syms[i]) begin
         sym_out.symbol      = run_syms[i];
         sym_out.drive_level = drive_levels[run_syms[i]];
         sym_out.last_of_run = (i == run_syms.size() - 1);
         expected_symbols.push_back(sym_out);
      end
      return run_syms.size();
   endfunction

   // Offers one transaction after a random gap and waits until it is taken.
   // Entered and left at a falling edge; push stays high on return.
   task automatic send_item(input req_payload_type item, output int produced);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push    <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      produced = predict_symbols(item);
      @(negedge clock);
   endtask

   // Stops offering, lets every owed symbol come out, then waits for the
   // block to finish any work that gives no symbol.
   task automatic drain;
      req_push <= 1'b0;
      while (expected_symbols.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Register write; entered and left at a falling edge with the enable high.
   task automatic write_level(logic [CSR_ADDR_W-1:0] addr, logic [LEVEL_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      if (addr <= CSR_LEVEL_SYM3) begin
         drive_levels[addr[1:0]] = value;
      end
      @(negedge clock);
   endtask

   // Writes all four levels, plus one write to an unmapped index that must
   // leave them alone.
   task automatic set_levels(logic [LEVEL_W-1:0] l0, logic [LEVEL_W-1:0] l1,
                             logic [LEVEL_W-1:0] l2, logic [LEVEL_W-1:0] l3);
      write_level(CSR_LEVEL_SYM0, l0);
      write_level(CSR_LEVEL_SYM1, l1);
      write_level(CSR_LEVEL_SYM2, l2);
      write_level(CSR_LEVEL_SYM3, l3);
      write_level(CSR_LEVEL_SYM3 + CSR_ADDR_W'($urandom_range(1, 4)), LEVEL_W'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic run_directed;
      req_payload_type item;
      int              produced;
      foreach (DIRECTED_ROWS[r]) begin
         repeat (DIRECTED_ROWS[r].reps) begin
            item.opcode    = DIRECTED_ROWS[r].opcode;
            item.data_byte = (DIRECTED_ROWS[r].reps > 1) ? 8'($urandom)
                                                         : DIRECTED_ROWS[r].data_byte;
            send_item(item, produced);
            if (DIRECTED_ROWS[r].exp_len != LEN_UNCHECKED &&
                produced != DIRECTED_ROWS[r].exp_len) begin
               report_mismatch($sformatf("directed row %0d gives %0d symbols, table says %0d",
                                         r, produced, DIRECTED_ROWS[r].exp_len));
            end
         end
      end
   endtask

   // Mostly whole messages of random bytes; now and then an empty message, one
   // of 30 to 36 bytes that can overflow the limit, or a message whose end is left out.
   task automatic random_traffic(int target);
      req_payload_type item;
      int              sent;
      int              length;
      int              pick;
      int              produced;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            length = 0;
         end else if (pick < 13) begin
            length = $urandom_range(30, 36);
         end else begin
            length = $urandom_range(1, 6);
         end
         repeat (length) begin
            item.opcode    = OP_DATA;
            item.data_byte = 8'($urandom);
            send_item(item, produced);
            if (produced != 0) sent++;
         end
         if ($urandom_range(99) < 85) begin
            item.opcode    = OP_END;
            item.data_byte = 8'($urandom);
            send_item(item, produced);
            sent++;
         end
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, logic [LEVEL_W-1:0] l0,
                            logic [LEVEL_W-1:0] l1, logic [LEVEL_W-1:0] l2,
                            logic [LEVEL_W-1:0] l3);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      set_levels(l0, l1, l2, l3);
      random_traffic(14);
      drain();
   endtask

   // The receiver stalls at random, at the rate the current phase sets.
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Each symbol taken is compared with the oldest one still owed.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_symbols.size() == 0) begin
            report_mismatch($sformatf("symbol %0d arrived with none owed", symbols_seen));
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_payload.symbol !== want.symbol) begin
               report_mismatch($sformatf("symbol %0d: value %0d, expected %0d",
                                         symbols_seen, rsp_payload.symbol, want.symbol));
            end
            if (rsp_payload.drive_level !== want.drive_level) begin
               report_mismatch($sformatf("symbol %0d: drive level %0d, expected %0d",
                                         symbols_seen, rsp_payload.drive_level,
                                         want.drive_level));
            end
            if (rsp_payload.last_of_run !== want.last_of_run) begin
               report_mismatch($sformatf("symbol %0d: last flag %0b, expected %0b",
                                         symbols_seen, rsp_payload.last_of_run,
                                         want.last_of_run));
            end
         end
         symbols_seen++;
      end
   end

   // Ends the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL four_level_symbol_framer");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed sequence with the levels left at their reset values.
      run_directed();
      drain();

      // Random phases, each with its own levels and idling pattern.
      run_phase(0, 0, 8'd0, 8'd0, 8'd0, 8'd0);
      run_phase(66, 0, 8'd255, 8'd255, 8'd255, 8'd255);
      run_phase(0, 66, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      run_phase(18, 18, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

      if (mismatches == 0) begin
         $display("PASS four_level_symbol_framer");
      end else begin
         $display("FAIL four_level_symbol_framer");
      end
      $finish;
   end

endmodule
